/* rtl/core/ctu_pkg.sv */
// ----------------------------------------------------------------------------
// ctu_pkg: shared definitions of the columnar transposition unit
// Register map codes, field widths, parameter defaults and the structs that
// carry configuration and control between the modules.
// ----------------------------------------------------------------------------
package ctu_pkg;

   localparam int MAX_LEN_DEF  = 64;
   localparam int MAX_COLS_DEF = 64;

   localparam int BYTE_W   = 8;
   localparam int TW_W     = 7;
   localparam int DATA_W   = 32;
   localparam int PADDR_W  = 4;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_TABLE_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_DOUBLE_PASS  = 2'd2;

   localparam logic [TW_W-1:0] TABLE_WIDTH_RST = 7'd1;

   typedef struct packed {
      logic [TW_W-1:0] table_width;
      logic            decrypt_mode;
      logic            double_pass;
   } cfg_type;

   typedef struct packed {
      logic ld_en;   // store an incoming byte into the message store
      logic cp_en;   // write the permuted byte read in the previous cycle
      logic dir;     // 0: message store is the source, 1: pass store is
   } mem_ctl_type;

   typedef struct packed {
      logic strobe;
      logic last;
      logic overflow;
   } rsp_ctl_type;

endpackage

/* rtl/core/ctu_ram.sv */
// ----------------------------------------------------------------------------
// ctu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ctu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ctu_csr.sv */
// ----------------------------------------------------------------------------
// ctu_csr: APB register block
// Holds table width, decrypt mode and double pass; writes complete in the
// access cycle, reads return the stored value.
// ----------------------------------------------------------------------------
module ctu_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ctu_pkg::PADDR_W-1:0]  paddr,
   input  logic [ctu_pkg::DATA_W-1:0]   pwdata,
   output logic [ctu_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output ctu_pkg::cfg_type             cfg
);
   import ctu_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_stb;

   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_stb  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_TABLE_WIDTH:  cfg_in.table_width  = pwdata[TW_W-1:0];
            REG_DECRYPT_MODE: cfg_in.decrypt_mode = pwdata[0];
            REG_DOUBLE_PASS:  cfg_in.double_pass  = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_width  <= TABLE_WIDTH_RST;
         cfg_ff.decrypt_mode <= 1'b0;
         cfg_ff.double_pass  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TABLE_WIDTH:  prdata = {{(DATA_W-TW_W){1'b0}}, cfg_ff.table_width};
         REG_DECRYPT_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_ff.decrypt_mode};
         REG_DOUBLE_PASS:  prdata = {{(DATA_W-1){1'b0}}, cfg_ff.double_pass};
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

/* rtl/core/ctu_seq.sv */
// ----------------------------------------------------------------------------
// ctu_seq: transposition sequencer
// Counts incoming bytes, walks the table column by column with one shared
// adder, drives the store addresses for each pass and paces the output.
// ----------------------------------------------------------------------------
module ctu_seq #(
   parameter int MAX_LEN  = ctu_pkg::MAX_LEN_DEF,
   parameter int MAX_COLS = ctu_pkg::MAX_COLS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctu_pkg::cfg_type           cfg,
   input  logic                       start,
   input  logic                       in_last,
   output logic                       busy,
   output ctu_pkg::mem_ctl_type       mem_ctl,
   output logic [$clog2(MAX_LEN)-1:0] ld_addr,
   output logic [$clog2(MAX_LEN)-1:0] rd_addr,
   output logic [$clog2(MAX_LEN)-1:0] cp_addr,
   output ctu_pkg::rsp_ctl_type       rsp_ctl
);
   import ctu_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int WW = $clog2(MAX_COLS + 1);
   localparam int PW = $clog2(MAX_LEN + MAX_COLS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PASS  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [WW-1:0]   col_ff, col_in;
   logic [AW-1:0]   k_ff, k_in;
   logic            second_ff, second_in;
   logic            dir_ff, dir_in;
   logic            cp_en_ff, cp_en_in;
   logic [AW-1:0]   cp_addr_ff, cp_addr_in;
   logic            strobe_ff, strobe_in;
   logic            last_ff, last_in;

   logic [WW-1:0]   width;
   logic [PW-1:0]   addend;
   logic [PW-1:0]   sum;
   logic [PW-1:0]   count_ext;
   logic            in_range;
   logic            accept;
   logic            ld_en;

   // Out-of-range widths are folded onto the nearest legal value.
   always_comb begin
      if (cfg.table_width == '0) begin
         width = WW'(1);
      end else if (cfg.table_width > TW_W'(MAX_COLS)) begin
         width = WW'(MAX_COLS);
      end else begin
         width = cfg.table_width[WW-1:0];
      end
   end

   // The shared adder: steps down a column during a pass, counts during output.
   assign addend    = (state_ff == ST_PASS) ? PW'(width) : PW'(1);
   assign sum       = pos_ff + addend;
   assign count_ext = PW'(count_ff);
   assign in_range  = pos_ff < count_ext;
   assign accept    = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      pos_in     = pos_ff;
      col_in     = col_ff;
      k_in       = k_ff;
      second_in  = second_ff;
      dir_in     = dir_ff;
      cp_en_in   = 1'b0;
      cp_addr_in = cp_addr_ff;
      strobe_in  = 1'b0;
      last_in    = last_ff;
      rd_addr    = pos_ff[AW-1:0];
      ld_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_LEN)) begin
                  ld_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_last) begin
                  state_in  = ST_PASS;
                  pos_in    = '0;
                  col_in    = '0;
                  k_in      = '0;
                  second_in = 1'b0;
               end
            end
         end
         ST_PASS: begin
            if (in_range) begin
               // Encrypt gathers from the table position, decrypt scatters to it.
               rd_addr    = cfg.decrypt_mode ? k_ff : pos_ff[AW-1:0];
               cp_addr_in = cfg.decrypt_mode ? pos_ff[AW-1:0] : k_ff;
               cp_en_in   = 1'b1;
               k_in       = k_ff + AW'(1);
               pos_in     = sum;
            end else if (col_ff == width - WW'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + WW'(1);
               pos_in = PW'(col_ff + WW'(1));
            end
         end
         ST_DRAIN: begin
            // The copy writes are done by now; dir flips so the next pass reads what they wrote.
            dir_in = ~dir_ff;
            pos_in = '0;
            col_in = '0;
            k_in   = '0;
            if (cfg.double_pass && !second_ff) begin
               second_in = 1'b1;
               state_in  = ST_PASS;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            last_in   = (sum == count_ext);
            pos_in    = sum;
            if (sum == count_ext) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
            dir_in   = 1'b0;
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         dir_ff    <= 1'b0;
         second_ff <= 1'b0;
         cp_en_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         dir_ff    <= dir_in;
         second_ff <= second_in;
         cp_en_ff  <= cp_en_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      col_ff     <= col_in;
      k_ff       <= k_in;
      cp_addr_ff <= cp_addr_in;
      last_ff    <= last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign ld_addr          = count_ff[AW-1:0];
   assign cp_addr          = cp_addr_ff;
   assign mem_ctl.ld_en    = ld_en;
   assign mem_ctl.cp_en    = cp_en_ff;
   assign mem_ctl.dir      = dir_ff;
   assign rsp_ctl.strobe   = strobe_ff;
   assign rsp_ctl.last     = last_ff;
   assign rsp_ctl.overflow = ovf_ff;

endmodule

/* rtl/core/columnar_transposition_unit.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_unit: keyless columnar transposition of one message
// Buffers a message, permutes it once or twice and streams it back out.
// ----------------------------------------------------------------------------
// A message is loaded one byte per cycle while busy is low; the byte that
// carries the last flag raises busy. Each pass then walks the table column
// by column, reading one byte a cycle from the source store's read port and
// taking a step to close each column. Output follows: one result per cycle,
// with rsp_strobe high for each. The receiver cannot stall the unit, so
// results must be taken as they appear. Bytes past MAX_LEN are dropped and
// every result of that message carries rsp_overflow.
// ----------------------------------------------------------------------------
module columnar_transposition_unit #(
   parameter int MAX_LEN  = ctu_pkg::MAX_LEN_DEF,
   parameter int MAX_COLS = ctu_pkg::MAX_COLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ctu_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_in_last,
   output logic                        rsp_strobe,
   output logic [ctu_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_out_last,
   output logic                        rsp_overflow,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ctu_pkg::PADDR_W-1:0] paddr,
   input  logic [ctu_pkg::DATA_W-1:0]  pwdata,
   output logic [ctu_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import ctu_pkg::*;

   localparam int AW = $clog2(MAX_LEN);

   cfg_type           cfg;
   mem_ctl_type       mem_ctl;
   rsp_ctl_type       rsp_ctl;
   logic [AW-1:0]     ld_addr;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     cp_addr;
   logic              msg_we;
   logic [AW-1:0]     msg_waddr;
   logic [BYTE_W-1:0] msg_wdata;
   logic [BYTE_W-1:0] msg_q;
   logic              pass_we;
   logic [BYTE_W-1:0] pass_q;

   ctu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ctu_seq #(
      .MAX_LEN  (MAX_LEN),
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .start   (start),
      .in_last (req_in_last),
      .busy    (busy),
      .mem_ctl (mem_ctl),
      .ld_addr (ld_addr),
      .rd_addr (rd_addr),
      .cp_addr (cp_addr),
      .rsp_ctl (rsp_ctl)
   );

   // The message store takes loads and the second pass; the pass store the first.
   assign msg_we    = mem_ctl.ld_en | (mem_ctl.cp_en & mem_ctl.dir);
   assign msg_waddr = mem_ctl.ld_en ? ld_addr : cp_addr;
   assign msg_wdata = mem_ctl.ld_en ? req_in_byte : pass_q;
   assign pass_we   = mem_ctl.cp_en & ~mem_ctl.dir;

   ctu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_we),
      .wr_addr (msg_waddr),
      .wr_data (msg_wdata),
      .rd_addr (rd_addr),
      .rd_data (msg_q)
   );

   ctu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_pass_ram (
      .clock   (clock),
      .wr_en   (pass_we),
      .wr_addr (cp_addr),
      .wr_data (msg_q),
      .rd_addr (rd_addr),
      .rd_data (pass_q)
   );

   assign rsp_strobe   = rsp_ctl.strobe;
   assign rsp_out_byte = mem_ctl.dir ? pass_q : msg_q;
   assign rsp_out_last = rsp_ctl.last;
   assign rsp_overflow = rsp_ctl.overflow;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the columnar transposition unit
// Streams messages into the unit under a range of table widths, directions
// and pass counts, predicts every permuted byte and checks each result
// transaction against the oldest prediction. Register writes are read back.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ctu_pkg::*;

   localparam int MSG_MAX     = MAX_LEN_DEF;
   localparam int COL_MAX     = MAX_COLS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              overflow;
   } cipher_byte_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                req_in_last = 1'b0;
   logic                psel        = 1'b0;
   logic                penable     = 1'b0;
   logic                pwrite      = 1'b0;
   logic [PADDR_W-1:0]  paddr       = '0;
   logic [DATA_W-1:0]   pwdata      = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_last;
   logic                rsp_overflow;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Shadow of the unit: configuration and the message being collected.
   logic [TW_W-1:0]     shadow_width   = TABLE_WIDTH_RST;
   logic                shadow_decrypt = 1'b0;
   logic                shadow_double  = 1'b0;
   logic [BYTE_W-1:0]   held_bytes [MSG_MAX];
   int                  held_count     = 0;
   logic                held_overflow  = 1'b0;

   cipher_byte_type     expected_cipher_q [$];
   int                  mismatches     = 0;
   int                  msgs_sent      = 0;
   int                  bytes_sent     = 0;
   int                  bytes_checked  = 0;
   int                  settings_used  = 0;
   int                  cycle_count    = 0;

   columnar_transposition_unit dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_overflow (rsp_overflow),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Permutes the collected message as the unit should and queues the bytes.
   task automatic predict_transposition();
      logic [BYTE_W-1:0] cur [MSG_MAX];
      logic [BYTE_W-1:0] nxt [MSG_MAX];
      int                order [MSG_MAX];
      int                n;
      int                w;
      int                rows;
      int                k;
      int                passes;
      cipher_byte_type   item;
      n = held_count;
      if (shadow_width == 0)
         w = 1;
      else if (shadow_width > COL_MAX)
         w = COL_MAX;
      else
         w = int'(shadow_width);
      rows = (n + w - 1) / w;
      // order[k] is the table position read k-th when going column by column.
      k = 0;
      for (int c = 0; c < w; c++) begin
         for (int r = 0; r < rows; r++) begin
            if (r * w + c < n) begin
               order[k] = r * w + c;
               k++;
            end
         end
      end
      for (int i = 0; i < n; i++)
         cur[i] = held_bytes[i];
      passes = shadow_double ? 2 : 1;
      for (int p = 0; p < passes; p++) begin
         for (int i = 0; i < n; i++) begin
            if (shadow_decrypt)
               nxt[order[i]] = cur[i];
            else
               nxt[i] = cur[order[i]];
         end
         for (int i = 0; i < n; i++)
            cur[i] = nxt[i];
      end
      for (int i = 0; i < n; i++) begin
         item.data     = cur[i];
         item.last     = (i == n - 1);
         item.overflow = held_overflow;
         expected_cipher_q.push_back(item);
      end
      held_count    = 0;
      held_overflow = 1'b0;
   endtask

   always @(posedge clock) begin
      cipher_byte_type want;
      if (!reset && rsp_strobe) begin
         if (expected_cipher_q.size() == 0) begin
            $display("%0t: unexpected result byte=%02h last=%0b overflow=%0b",
                     $time, rsp_out_byte, rsp_out_last, rsp_overflow);
            mismatches++;
         end else begin
            want = expected_cipher_q.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_out_last !== want.last) begin
               $display("%0t: out_last expected %0b actual %0b",
                        $time, want.last, rsp_out_last);
               mismatches++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_overflow);
               mismatches++;
            end
         end
      end
   end

   // Offers one byte and returns once the unit has taken it.
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
      @(negedge clock);
      start       <= 1'b1;
      req_in_byte <= value;
      req_in_last <= is_last;
      do @(posedge clock); while (busy);
      if (held_count < MSG_MAX) begin
         held_bytes[held_count] = value;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      bytes_sent++;
      if (is_last) begin
         predict_transposition();
         msgs_sent++;
      end
   endtask

   task automatic hold_start_low(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic send_message(input int len, input int idle_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < idle_pct)
            hold_start_low($urandom_range(1, 6));
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Lets every predicted byte come out and the unit fall idle.
   task automatic wait_results_done();
      @(negedge clock);
      start <= 1'b0;
      while (expected_cipher_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Writes one register, reads it back and updates the shadow copy.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== value) begin
         $display("%0t: register %0d readback expected %08h actual %08h",
                  $time, idx, value, readback);
         mismatches++;
      end
      case (idx)
         REG_TABLE_WIDTH:  shadow_width   = value[TW_W-1:0];
         REG_DECRYPT_MODE: shadow_decrypt = value[0];
         REG_DOUBLE_PASS:  shadow_double  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_cipher_config(input int width, input logic decrypt,
                                    input logic dbl);
      wait_results_done();
      csr_write(REG_TABLE_WIDTH, DATA_W'(width));
      csr_write(REG_DECRYPT_MODE, DATA_W'(decrypt));
      csr_write(REG_DOUBLE_PASS, DATA_W'(dbl));
      settings_used++;
   endtask

   task automatic test_reset_defaults();
      // Width 1 after reset passes the message through unchanged.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_short_last_row();
      set_cipher_config(3, 1'b0, 1'b0);
      send_message(7, 0);
      set_cipher_config(3, 1'b1, 1'b0);
      send_message(5, 0);
   endtask

   task automatic test_double_pass();
      set_cipher_config(2, 1'b0, 1'b1);
      send_message(4, 0);
   endtask

   task automatic test_width_limits();
      // Zero width acts as one column; the largest code clamps to the maximum,
      // which also exceeds the message length and leaves it unchanged.
      set_cipher_config(0, 1'b0, 1'b0);
      send_message(2, 0);
      set_cipher_config(127, 1'b1, 1'b1);
      send_message(2, 0);
   endtask

   task automatic test_buffer_overflow();
      // A message that fills the store and then loses its last two bytes,
      // the final one carrying the last flag.
      set_cipher_config(5, 1'b1, 1'b1);
      send_message(MSG_MAX + 2, 0);
   endtask

   task automatic test_random_traffic();
      int idle_pct [3] = '{0, 53, 24};
      int budget;
      int len;
      int width;
      for (int ph = 0; ph < 3; ph++) begin
         for (int s = 0; s < 2; s++) begin
            case ($urandom_range(0, 5))
               0:       width = 0;
               1:       width = $urandom_range(64, 127);
               default: width = $urandom_range(1, 12);
            endcase
            set_cipher_config(width, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            budget = 0;
            while (budget < 3) begin
               if ($urandom_range(0, 7) == 0)
                  len = $urandom_range(5, 9);
               else
                  len = $urandom_range(1, 4);
               send_message(len, idle_pct[ph]);
               budget += len;
               // Now and then the sender holds off until the unit has drained.
               if (ph == 0 && s == 0 && budget == len)
                  wait_results_done();
               else if ($urandom_range(0, 3) == 0)
                  wait_results_done();
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_short_last_row();
      test_double_pass();
      test_width_limits();
      test_buffer_overflow();
      test_random_traffic();

      wait_results_done();
      if (expected_cipher_q.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, expected_cipher_q.size());
         mismatches += expected_cipher_q.size();
      end
      $display("Ran %0d messages (%0d bytes in, %0d bytes checked) under %0d settings,",
               msgs_sent, bytes_sent, bytes_checked, settings_used);
      $display("including zero, clamped and over-length widths, both directions and overflow.");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
